// ----- hw/rtl/olae_pkg.sv -----
`timescale 1ns / 1ps

package olae_pkg;

   localparam int DEFAULT_CAPACITY = 128;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 8;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   localparam logic [KIND_W-1:0] REQ_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] REQ_DELETE = 3'd1;
   localparam logic [KIND_W-1:0] REQ_READ   = 3'd2;
   localparam logic [KIND_W-1:0] REQ_SEARCH = 3'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_INS  = 6'b000010,
      S_PUT  = 6'b000100,
      S_DEL  = 6'b001000,
      S_RD   = 6'b010000,
      S_SRCH = 6'b100000
   } state_type;

endpackage

// ----- hw/rtl/olae_ram.sv -----
`timescale 1ns / 1ps

module olae_ram
   import olae_pkg::*;
#(
   parameter int DEPTH = DEFAULT_CAPACITY,
   parameter int WIDTH = VAL_W,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/ordered_array_list_engine.sv -----
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values held in one single-port-read, single-port-write
// memory of CAPACITY entries. A request is taken when start is high and busy is low, and
// exactly one result follows, shown for one cycle with rsp_strobe; the receiver cannot
// stall it. Entries move one per cycle: an insert at p moves those from the last down
// to p up one, then writes the value; a delete at p moves those from p+1 to the last
// down one (none when p is the last); a search reads from the first to a match or the
// last; status and refused requests keep busy low. The result appears in the first
// cycle that busy is low again, or in the cycle after acceptance when busy never rises.
// A new request may be accepted in the same cycle that a result is shown.
module ordered_array_list_engine
   import olae_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [KIND_W-1:0]          req_type,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VAL_W-1:0]    req_value,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VAL_W-1:0]    rsp_read_value,
   output logic [POS_W-1:0]           rsp_found_position,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_is_empty
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [EW-1:0] CAP_X = EW'(CAPACITY);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] pos_m1_ff, pos_m1_in;
   logic [VAL_W-1:0] val_ff, val_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0] rsp_read_ff, rsp_read_in;
   logic [POS_W-1:0] rsp_fp_ff, rsp_fp_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_empty_ff, rsp_empty_in;

   logic mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [VAL_W-1:0] mem_rd_data;
   logic mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [VAL_W-1:0] mem_wr_data;

   logic [EW-1:0] pos_x;
   logic [EW-1:0] cnt_x;
   logic [EW-1:0] pos_m1_x;
   logic [EW-1:0] fp_x;
   logic [AW-1:0] last_addr;
   logic accept;

   olae_ram #(
      .DEPTH(CAPACITY),
      .WIDTH(VAL_W)
   ) u_ram (
      .clock  (clock),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign pos_x     = EW'(req_position);
   assign cnt_x     = EW'(count_ff);
   assign pos_m1_x  = pos_x - EW'(1);
   assign fp_x      = EW'(addr_ff) + EW'(1);
   assign last_addr = AW'(count_ff - CW'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      pos_m1_in     = pos_m1_ff;
      val_in        = val_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_read_in   = '0;
      rsp_fp_in     = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_m1_in = pos_m1_x[AW-1:0];
               val_in    = req_value;
               case (req_type)
                  REQ_INSERT: begin
                     if (cnt_x >= CAP_X) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (pos_x == '0 || pos_x > cnt_x + EW'(1)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_BADPOS;
                     end else if (pos_x == cnt_x + EW'(1)) begin
                        state_in = S_PUT;
                     end else begin
                        // Walk down from the last entry, one move per cycle.
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = last_addr;
                        addr_in     = last_addr;
                        state_in    = S_INS;
                     end
                  end
                  REQ_DELETE: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_BADPOS;
                     end else if (pos_x == cnt_x) begin
                        count_in      = count_ff - CW'(1);
                        rsp_strobe_in = 1'b1;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = pos_x[AW-1:0];
                        addr_in     = pos_x[AW-1:0];
                        state_in    = S_DEL;
                     end
                  end
                  REQ_READ: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = pos_m1_x[AW-1:0];
                        state_in    = S_RD;
                     end
                  end
                  REQ_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        addr_in     = '0;
                        state_in    = S_SRCH;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_INS: begin
            // The entry read last cycle moves up one place while the next one is read.
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_ff + AW'(1);
            if (addr_ff == pos_m1_ff) begin
               state_in = S_PUT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = addr_ff - AW'(1);
               addr_in     = addr_ff - AW'(1);
            end
         end
         S_PUT: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = pos_m1_ff;
            mem_wr_data   = val_ff;
            count_in      = count_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_DEL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_ff - AW'(1);
            if (addr_ff == last_addr) begin
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = addr_ff + AW'(1);
               addr_in     = addr_ff + AW'(1);
            end
         end
         S_RD: begin
            rsp_strobe_in = 1'b1;
            rsp_read_in   = mem_rd_data;
            state_in      = S_IDLE;
         end
         S_SRCH: begin
            if (mem_rd_data == val_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_fp_in     = fp_x[POS_W-1:0];
               state_in      = S_IDLE;
            end else if (addr_ff == last_addr) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_NOTFOUND;
               state_in      = S_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = addr_ff + AW'(1);
               addr_in     = addr_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = COUNT_W'(count_in);
      rsp_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      pos_m1_ff <= pos_m1_in;
      val_ff    <= val_in;
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_fp_ff     <= rsp_fp_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_found_position = rsp_fp_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;

   // Every accepted request either answers at once or raises busy.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted request neither answered nor started");

   assert property (@(posedge clock) disable iff (reset)
      EW'(count_ff) <= CAP_X)
      else $error("entry count exceeds capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (count_ff == '0)))
      else $error("empty flag disagrees with entry count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(state_ff) == S_SRCH && rsp_status == ST_OK)
         |-> (rsp_found_position != '0 || CAPACITY > 255))
      else $error("search hit reported without a position");

endmodule
